### rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### rtl/gmrf_pkg.sv
`timescale 1ns / 1ps
package gmrf_pkg;
   localparam int DATA_W       = 10;
   localparam int WINDOW_DEF   = 5;
   localparam logic [DATA_W-1:0] NO_ECHO_CODE = 10'd999;
   localparam logic [DATA_W-1:0] LIMIT_RESET  = 10'd300;

   // control broadcast to every cell
   typedef struct packed {
      logic insert;   // a kept sample goes into the chain
      logic clear;    // window done, drop all samples
   } gmrf_ctrl_type;
endpackage

### rtl/gated_median_range_filter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// gated median range filter
// req channel carries one range sample in cm per request; samples come in
// windows of WINDOW. a sample is kept when it is above zero and below the
// limit in the csr register (reset 300). kept samples drop into a sorted
// chain of WINDOW cells, one insertion per cycle outside readout, each
// cell deciding alone whether to hold, take the new sample or its left neighbor.
// after the last sample of a window a readout step reads the cell at
// position count/2 into the output register and clears the chain.
// rsp channel gives one result per window: the median, or 999 with the
// no-echo flag in tuser when nothing was kept.
// throughput: one request per cycle inside a window. after the window's last
// request req_tready stays low until the median readout, which loads the
// result and rsp_tvalid into the output register.
// reset (synchronous) empties the chain, clears the counters and the output
// valid flag and reloads the limit. if rsp stalls, a finished result waits in
// the output register while the next window's samples are still taken; only
// the readout of the following window waits for the register to free up.
module gated_median_range_filter import gmrf_pkg::*; #(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // req_tdata: sample_cm [9:0], zero pad [15:10]
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,
   // rsp_tdata: distance_cm [9:0], zero pad [15:10]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,
   // rsp_tuser: no_echo [0]
   output logic              rsp_tuser,
   input  logic              csr_wr_en,
   input  logic [DATA_W-1:0] csr_wr_data
);
   localparam int CNT_W = $clog2(WINDOW + 1);

   logic [DATA_W-1:0] limit_ff;
   logic [CNT_W-1:0]  kept_count_ff, kept_count_in;
   logic [CNT_W-1:0]  window_pos_ff, window_pos_in;
   logic              finish_ff, finish_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic              rsp_flag_ff, rsp_flag_in;

   logic [DATA_W-1:0] sample;
   logic              req_accept, keep, readout;
   gmrf_ctrl_type     ctrl;

   // chain wiring, index 0 is the left edge (fixed inputs)
   logic [DATA_W-1:0] chain_val [WINDOW+1];
   logic              chain_greater [WINDOW+1];
   logic              chain_occ [WINDOW+1];
   logic [WINDOW-1:0] occ_vec;
   logic [DATA_W-1:0] median;

   assign sample     = req_tdata[DATA_W-1:0];
   assign req_tready = !finish_ff;
   assign req_accept = req_tvalid && req_tready;
   assign keep       = (sample != '0) && (sample < limit_ff);
   // readout happens once the output register is free or being emptied
   assign readout    = finish_ff && (!rsp_valid_ff || rsp_tready);

   assign ctrl.insert = req_accept && keep;
   assign ctrl.clear  = readout;

   assign chain_val[0]     = sample;
   assign chain_greater[0] = 1'b0;
   assign chain_occ[0]     = 1'b1;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      gmrf_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .new_val      (sample),
         .left_val     (chain_val[i]),
         .left_greater (chain_greater[i]),
         .left_occ     (chain_occ[i]),
         .val          (chain_val[i+1]),
         .greater      (chain_greater[i+1]),
         .occ          (chain_occ[i+1])
      );
      assign occ_vec[i] = chain_occ[i+1];
   end

   // pick the cell at count/2
   always_comb begin
      median = '0;
      for (int i = 0; i < WINDOW; i++) begin
         if (CNT_W'(i) == (kept_count_ff >> 1)) begin
            median = chain_val[i+1];
         end
      end
   end

   always_comb begin
      kept_count_in = kept_count_ff;
      window_pos_in = window_pos_ff;
      finish_in     = finish_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_flag_in   = rsp_flag_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         if (keep) begin
            kept_count_in = kept_count_ff + 1'b1;
         end
         if (window_pos_ff == CNT_W'(WINDOW - 1)) begin
            window_pos_in = '0;
            finish_in     = 1'b1;
         end else begin
            window_pos_in = window_pos_ff + 1'b1;
         end
      end
      if (readout) begin
         finish_in     = 1'b0;
         kept_count_in = '0;
         rsp_valid_in  = 1'b1;
         if (kept_count_ff == '0) begin
            rsp_dist_in = NO_ECHO_CODE;
            rsp_flag_in = 1'b1;
         end else begin
            rsp_dist_in = median;
            rsp_flag_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         kept_count_ff <= '0;
         window_pos_ff <= '0;
         finish_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         kept_count_ff <= kept_count_in;
         window_pos_ff <= window_pos_in;
         finish_ff     <= finish_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff <= rsp_dist_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - DATA_W){1'b0}}, rsp_dist_ff};
   assign rsp_tuser  = rsp_flag_ff;

   // occupied cells always match the kept count
   `ASSERT_IMPLY(a_occ_count, clock, reset, 1'b1, $countones(occ_vec) == kept_count_ff)
   // outside readout, no more kept than taken in this window
   `ASSERT_IMPLY(a_count_pos, clock, reset, !finish_ff, kept_count_ff <= window_pos_ff)
   // a readout leaves an empty chain and a pending result
   `ASSERT_NEXT(a_readout, clock, reset, readout, (kept_count_ff == '0) && rsp_valid_ff)
   // no-echo results always carry the no-echo code
   `ASSERT_IMPLY(a_no_echo, clock, reset, rsp_tvalid && rsp_tuser, rsp_dist_ff == NO_ECHO_CODE)
endmodule

### rtl/gmrf_cell.sv
`timescale 1ns / 1ps
module gmrf_cell import gmrf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  gmrf_ctrl_type     ctrl,
   input  logic [DATA_W-1:0] new_val,
   input  logic [DATA_W-1:0] left_val,
   input  logic              left_greater,
   input  logic              left_occ,
   output logic [DATA_W-1:0] val,
   output logic              greater,
   output logic              occ
);
   logic [DATA_W-1:0] val_ff, val_in;
   logic              occ_ff, occ_in;

   // empty cells count as greater, so the greater flags form a suffix
   assign greater = !occ_ff || (val_ff > new_val);
   assign val     = val_ff;
   assign occ     = occ_ff;

   always_comb begin
      val_in = val_ff;
      occ_in = occ_ff;
      if (ctrl.clear) begin
         occ_in = 1'b0;
      end else if (ctrl.insert) begin
         if (greater) begin
            val_in = left_greater ? left_val : new_val;
         end
         occ_in = occ_ff | left_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end
endmodule
